/* rtl/core/svrcm_pkg.sv */
// shared types and constants for the stereo volume ramp and channel mix block
`timescale 1ns / 1ps

package svrcm_pkg;

   localparam int SAMPLE_W    = 16;
   localparam int GAIN_W      = 16;
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 16;
   localparam int RAMP_SHIFT  = 8;
   localparam int Q_SHIFT     = 15;
   // signed sample times gain widened by a zero bit
   localparam int PROD_W      = SAMPLE_W + GAIN_W + 1;

   localparam logic [GAIN_W-1:0] UNITY_GAIN        = 16'h8000;
   localparam logic [GAIN_W-1:0] TARGET_GAIN_RESET = UNITY_GAIN;

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_TARGET_GAIN  = 1'd0,
      REG_CHANNEL_MODE = 1'd1
   } reg_index_type;

   typedef enum logic [1:0] {
      MODE_STEREO = 2'd0,
      MODE_LEFT   = 2'd1,
      MODE_RIGHT  = 2'd2,
      MODE_MONO   = 2'd3
   } channel_mode_type;

   // frame after the gain update, before scaling
   typedef struct packed {
      logic signed [SAMPLE_W-1:0] left_sample;
      logic signed [SAMPLE_W-1:0] right_sample;
      logic                       frame_last;
      logic [GAIN_W-1:0]          gain;
      logic                       bypass;
   } gain_stage_type;

   // frame after scaling, before channel routing
   typedef struct packed {
      logic signed [SAMPLE_W-1:0] left_sample;
      logic signed [SAMPLE_W-1:0] right_sample;
      logic                       frame_last;
   } scale_stage_type;

endpackage

/* rtl/core/svrcm_if.sv */
// channel interfaces for frames, results and register writes
`timescale 1ns / 1ps

interface svrcm_req_if import svrcm_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic signed [SAMPLE_W-1:0] left_sample;
   logic signed [SAMPLE_W-1:0] right_sample;
   logic                       frame_last;

   modport source (output valid, left_sample, right_sample, frame_last, input ready);
   modport sink   (input valid, left_sample, right_sample, frame_last, output ready);
endinterface

interface svrcm_rsp_if import svrcm_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic signed [SAMPLE_W-1:0] left_out;
   logic signed [SAMPLE_W-1:0] right_out;
   logic                       last_out;

   modport source (output valid, left_out, right_out, last_out, input ready);
   modport sink   (input valid, left_out, right_out, last_out, output ready);
endinterface

interface svrcm_csr_if import svrcm_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic [CSR_INDEX_W-1:0] index;
   logic [CSR_DATA_W-1:0]  wdata;

   modport source (output valid, index, wdata, input ready);
   modport sink   (input valid, index, wdata, output ready);
endinterface

/* rtl/core/svrcm_gain_ramp.sv */
// held gain ramp and input register stage
`timescale 1ns / 1ps

module svrcm_gain_ramp import svrcm_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   svrcm_req_if.sink         req,
   input  logic [GAIN_W-1:0] target_gain,
   input  logic              next_ready,
   output logic              stage_valid,
   output gain_stage_type    stage_data
);

   logic                    valid_ff;
   gain_stage_type          data_ff;
   gain_stage_type          data_in;
   logic [GAIN_W-1:0]       gain_ff;
   logic [GAIN_W-1:0]       gain_in;
   logic                    gain_set_ff;
   logic                    gain_set_in;
   logic                    accept;
   logic                    bypass;
   logic signed [GAIN_W:0]  diff;
   logic signed [GAIN_W:0]  step;
   logic signed [GAIN_W:0]  step_min;

   assign req.ready   = !valid_ff || next_ready;
   assign accept      = req.valid && req.ready;
   assign bypass      = (target_gain == UNITY_GAIN);
   assign stage_valid = valid_ff;
   assign stage_data  = data_ff;

   // difference over 256, truncated toward zero, never less than one step
   always_comb begin
      diff = $signed({1'b0, target_gain}) - $signed({1'b0, gain_ff});
      if (diff[GAIN_W]) begin
         step = (diff + (GAIN_W+1)'(255)) >>> RAMP_SHIFT;
      end else begin
         step = diff >>> RAMP_SHIFT;
      end
      if (step == '0) begin
         step_min = diff[GAIN_W] ? '1 : (GAIN_W+1)'(1);
      end else begin
         step_min = step;
      end
   end

   always_comb begin
      gain_in     = gain_ff;
      gain_set_in = gain_set_ff;
      if (!bypass) begin
         if (!gain_set_ff) begin
            gain_in     = target_gain;
            gain_set_in = 1'b1;
         end else if (gain_ff != target_gain) begin
            gain_in = gain_ff + step_min[GAIN_W-1:0];
         end
      end
      data_in.left_sample  = req.left_sample;
      data_in.right_sample = req.right_sample;
      data_in.frame_last   = req.frame_last;
      data_in.gain         = gain_in;
      data_in.bypass       = bypass;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= 1'b0;
         gain_ff     <= '0;
         gain_set_ff <= 1'b0;
      end else begin
         if (req.ready) begin
            valid_ff <= req.valid;
         end
         if (accept) begin
            gain_ff     <= gain_in;
            gain_set_ff <= gain_set_in;
         end
      end
      if (accept) begin
         data_ff <= data_in;
      end
   end

endmodule

/* rtl/core/svrcm_scale.sv */
// q15 multiply stage for both channels
`timescale 1ns / 1ps

module svrcm_scale import svrcm_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            in_valid,
   input  gain_stage_type  in_data,
   output logic            in_ready,
   input  logic            next_ready,
   output logic            stage_valid,
   output scale_stage_type stage_data
);

   logic                     valid_ff;
   scale_stage_type          data_ff;
   scale_stage_type          data_in;
   logic signed [PROD_W-1:0] prod_left;
   logic signed [PROD_W-1:0] prod_right;

   assign in_ready    = !valid_ff || next_ready;
   assign stage_valid = valid_ff;
   assign stage_data  = data_ff;

   // gain is unsigned, so widen with a zero before the signed multiply
   assign prod_left  = in_data.left_sample  * $signed({1'b0, in_data.gain});
   assign prod_right = in_data.right_sample * $signed({1'b0, in_data.gain});

   always_comb begin
      data_in.frame_last = in_data.frame_last;
      if (in_data.bypass) begin
         data_in.left_sample  = in_data.left_sample;
         data_in.right_sample = in_data.right_sample;
      end else begin
         // floor shift then wrap to 16 bits
         data_in.left_sample  = prod_left[Q_SHIFT +: SAMPLE_W];
         data_in.right_sample = prod_right[Q_SHIFT +: SAMPLE_W];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

endmodule

/* rtl/core/svrcm_mix.sv */
// channel routing and result register
`timescale 1ns / 1ps

module svrcm_mix import svrcm_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   input  scale_stage_type  in_data,
   output logic             in_ready,
   input  channel_mode_type channel_mode,
   svrcm_rsp_if.source      rsp
);

   logic                       valid_ff;
   scale_stage_type            data_ff;
   scale_stage_type            data_in;
   logic signed [SAMPLE_W:0]   sum;
   logic signed [SAMPLE_W:0]   half;

   assign in_ready      = !valid_ff || rsp.ready;
   assign rsp.valid     = valid_ff;
   assign rsp.left_out  = data_ff.left_sample;
   assign rsp.right_out = data_ff.right_sample;
   assign rsp.last_out  = data_ff.frame_last;

   // mono halves toward zero: add one before the shift when negative
   always_comb begin
      sum  = $signed({in_data.left_sample[SAMPLE_W-1], in_data.left_sample})
           + $signed({in_data.right_sample[SAMPLE_W-1], in_data.right_sample});
      half = (sum + $signed({{SAMPLE_W{1'b0}}, sum[SAMPLE_W]})) >>> 1;
   end

   always_comb begin
      data_in = in_data;
      case (channel_mode)
         MODE_STEREO: begin
            data_in = in_data;
         end
         MODE_LEFT: begin
            data_in.right_sample = in_data.left_sample;
         end
         MODE_RIGHT: begin
            data_in.left_sample = in_data.right_sample;
         end
         MODE_MONO: begin
            data_in.left_sample  = half[SAMPLE_W-1:0];
            data_in.right_sample = half[SAMPLE_W-1:0];
         end
         default: begin
            data_in = in_data;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

endmodule

/* rtl/core/stereo_volume_ramp_and_channel_mix_top.sv */
// top level of the stereo volume ramp and channel mix block
`timescale 1ns / 1ps

// Takes one signed 16-bit stereo frame per transaction on req_chan and returns
// one processed frame per transaction on rsp_chan, in order. A new frame can be
// taken every clock cycle while the result side is not stalled; each frame
// passes three register stages (gain update, q15 multiply, channel routing)
// in that order on its way to rsp_chan. Stages advance
// independently, so the input keeps taking frames while bubbles remain ahead.
// Register 0 is the q15 target gain (32768 is unity and bypasses scaling, reset
// value); register 1 is the channel mode (stereo, left, right, mono average).
// The held gain moves toward the target by one ramp step per scaled frame; the
// first scaled frame after reset loads the target directly. Write the
// registers only while no frame is in flight.

module stereo_volume_ramp_and_channel_mix_top import svrcm_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   svrcm_req_if.sink   req_chan,
   svrcm_rsp_if.source rsp_chan,
   svrcm_csr_if.sink   csr_chan
);

   logic [GAIN_W-1:0] target_gain_ff;
   channel_mode_type  channel_mode_ff;
   logic              s1_valid;
   gain_stage_type    s1_data;
   logic              s1_ready;
   logic              s2_valid;
   scale_stage_type   s2_data;
   logic              s2_ready;

   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         target_gain_ff  <= TARGET_GAIN_RESET;
         channel_mode_ff <= MODE_STEREO;
      end else if (csr_chan.valid) begin
         case (reg_index_type'(csr_chan.index))
            REG_TARGET_GAIN: begin
               target_gain_ff <= csr_chan.wdata[GAIN_W-1:0];
            end
            REG_CHANNEL_MODE: begin
               channel_mode_ff <= channel_mode_type'(csr_chan.wdata[1:0]);
            end
            default: begin
               target_gain_ff <= target_gain_ff;
            end
         endcase
      end
   end

   svrcm_gain_ramp u_gain_ramp (
      .clock       (clock),
      .reset       (reset),
      .req         (req_chan),
      .target_gain (target_gain_ff),
      .next_ready  (s1_ready),
      .stage_valid (s1_valid),
      .stage_data  (s1_data)
   );

   svrcm_scale u_scale (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (s1_valid),
      .in_data     (s1_data),
      .in_ready    (s1_ready),
      .next_ready  (s2_ready),
      .stage_valid (s2_valid),
      .stage_data  (s2_data)
   );

   svrcm_mix u_mix (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (s2_valid),
      .in_data      (s2_data),
      .in_ready     (s2_ready),
      .channel_mode (channel_mode_ff),
      .rsp          (rsp_chan)
   );

endmodule
